### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on clk_i, off during reset
`define TFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication on clk_i, off during reset
`define TFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// format codes, register indexes and stage types of the texel format converter
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam logic [2:0] FMT_RGBA8     = 3'd0;
  localparam logic [2:0] FMT_BGRA8     = 3'd1;
  localparam logic [2:0] FMT_RGBA8_HDR = 3'd2;
  localparam logic [2:0] FMT_BGRA8_HDR = 3'd3;
  localparam logic [2:0] FMT_RGBA16    = 3'd4;
  localparam logic [2:0] FMT_HALF      = 3'd5;

  localparam logic CFG_SOURCE_FORMAT = 1'b0;
  localparam logic CFG_TARGET_FORMAT = 1'b1;

  localparam logic [2:0] SOURCE_FORMAT_RESET = FMT_RGBA8;
  localparam logic [2:0] TARGET_FORMAT_RESET = FMT_BGRA8;

  localparam logic [15:0] UNORM16_MAX   = 16'hffff;
  localparam logic [7:0]  UNORM8_MAX    = 8'hff;
  localparam logic [15:0] HALF_ONE      = 16'h3c00;
  localparam logic [4:0]  HALF_EXP_MAX  = 5'd31;
  localparam logic [4:0]  HALF_EXP_BIAS = 5'd15;

  typedef enum logic [2:0] {
    MODE_ZERO = 3'd0,
    MODE_PASS = 3'd1,
    MODE_U8   = 3'd2,
    MODE_U16  = 3'd3,
    MODE_HALF = 3'd4
  } mode_e;

  // decoded texel: channels as unorm16 or half
  typedef struct packed {
    mode_e            mode;
    logic             swap_rb;
    logic             is_half;
    logic [63:0]      raw;
    logic [3:0][15:0] ch;
    logic             last;
  } dec_t;

  // per channel intermediate terms
  typedef struct packed {
    logic [15:0] u;
    logic [7:0]  u8;
    logic        h_sat;
    logic        h_zero;
    logic [4:0]  h_sh;
    logic [18:0] h_p8;
    logic [26:0] h_p16;
    logic        f_zero;
    logic        f_one;
    logic        f_tiny;
    logic [3:0]  f_exp;
    logic [15:0] f_norm;
  } chp_t;

  typedef struct packed {
    mode_e       mode;
    logic        swap_rb;
    logic        is_half;
    logic [63:0] raw;
    chp_t [3:0]  ch;
    logic        last;
  } prep_t;

endpackage

### hw/rtl/tfc_decode.sv
// ----------------------------------------------------------------------------
// tfc_decode
// first stage: unpacks the source texel into four channels and picks the mode
// ----------------------------------------------------------------------------
module tfc_decode
  import tfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [2:0]  src_fmt_i,
  input  logic [2:0]  dst_fmt_i,
  input  logic [63:0] raw_i,
  input  logic        last_i,
  output logic        valid_o,
  output dec_t        dec_o
);

  logic valid_q;
  dec_t dec_d, dec_q;

  function automatic logic [15:0] hdr_chan(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] prod;
    prod = 16'(c) * 16'(a);
    return (|prod[15:12]) ? UNORM16_MAX : {prod[11:0], 4'b0};
  endfunction

  always_comb begin
    dec_d         = '0;
    dec_d.mode    = MODE_ZERO;
    dec_d.last    = last_i;
    dec_d.raw     = (dst_fmt_i inside {[FMT_RGBA16:FMT_HALF]}) ? raw_i : {32'b0, raw_i[31:0]};
    case (src_fmt_i)
      FMT_RGBA8, FMT_BGRA8: begin
        for (int i = 0; i < 4; i++) begin
          dec_d.ch[i] = {raw_i[8*i +: 8], raw_i[8*i +: 8]};
        end
        if (src_fmt_i == FMT_BGRA8) begin
          dec_d.ch[0] = {raw_i[23:16], raw_i[23:16]};
          dec_d.ch[2] = {raw_i[7:0], raw_i[7:0]};
        end
      end
      FMT_RGBA8_HDR, FMT_BGRA8_HDR: begin
        dec_d.ch[0] = hdr_chan(raw_i[23:16], raw_i[31:24]);
        dec_d.ch[1] = hdr_chan(raw_i[15:8], raw_i[31:24]);
        dec_d.ch[2] = hdr_chan(raw_i[7:0], raw_i[31:24]);
        dec_d.ch[3] = UNORM16_MAX;
      end
      FMT_RGBA16, FMT_HALF: begin
        for (int i = 0; i < 4; i++) begin
          dec_d.ch[i] = raw_i[16*i +: 16];
        end
        dec_d.is_half = (src_fmt_i == FMT_HALF);
      end
      default: ;
    endcase
    if (!(dst_fmt_i inside {[FMT_RGBA8:FMT_HALF]})) begin
      dec_d.mode = MODE_ZERO;
    end else if (src_fmt_i == dst_fmt_i) begin
      dec_d.mode = MODE_PASS;
    end else begin
      case (dst_fmt_i)
        FMT_RGBA8:  dec_d.mode = MODE_U8;
        FMT_BGRA8: begin
          dec_d.mode    = MODE_U8;
          dec_d.swap_rb = 1'b1;
        end
        FMT_RGBA16: dec_d.mode = MODE_U16;
        FMT_HALF:   dec_d.mode = MODE_HALF;
        default:    dec_d.mode = MODE_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

### hw/rtl/tfc_prep.sv
// ----------------------------------------------------------------------------
// tfc_prep
// second stage: half products and shifts, unorm8 quotient, leading one
// normalize for the half encoder
// ----------------------------------------------------------------------------
module tfc_prep
  import tfc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  dec_t  dec_i,
  output logic  valid_o,
  output prep_t prep_o
);

  logic  valid_q;
  prep_t prep_d, prep_q;

  function automatic chp_t prep_chan(input logic [15:0] u);
    chp_t        c;
    logic [4:0]  ex;
    logic [10:0] m;
    logic [15:0] x;
    logic [3:0]  lz;
    c    = '0;
    c.u  = u;
    // divide by 257: high byte is exact or one too large
    c.u8 = ({u[15:8], u[15:8]} > u) ? (u[15:8] - 8'd1) : u[15:8];
    ex   = u[14:10];
    if (ex == HALF_EXP_MAX) begin
      c.h_sat  = (u[9:0] != 10'd0) || !u[15];
      c.h_zero = !c.h_sat;
    end else if (u[15]) begin
      c.h_zero = 1'b1;
    end else if (ex >= HALF_EXP_BIAS) begin
      c.h_sat = 1'b1;
    end
    m       = (ex == 5'd0) ? {1'b0, u[9:0]} : {1'b1, u[9:0]};
    c.h_sh  = (ex == 5'd0) ? 5'd24 : (5'd25 - ex);
    c.h_p8  = {m, 8'b0} - 19'(m);
    c.h_p16 = {m, 16'b0} - 27'(m);
    x     = u;
    lz[3] = (x[15:8] == 8'd0);
    if (lz[3]) x = {x[7:0], 8'b0};
    lz[2] = (x[15:12] == 4'd0);
    if (lz[2]) x = {x[11:0], 4'b0};
    lz[1] = (x[15:14] == 2'd0);
    if (lz[1]) x = {x[13:0], 2'b0};
    lz[0] = !x[15];
    if (lz[0]) x = {x[14:0], 1'b0};
    c.f_norm = x;
    c.f_exp  = ~lz;
    c.f_zero = (u == 16'd0);
    c.f_one  = (u == UNORM16_MAX);
    c.f_tiny = (u[15:2] == 14'd0);
    return c;
  endfunction

  always_comb begin
    prep_d.mode    = dec_i.mode;
    prep_d.swap_rb = dec_i.swap_rb;
    prep_d.is_half = dec_i.is_half;
    prep_d.raw     = dec_i.raw;
    prep_d.last    = dec_i.last;
    for (int i = 0; i < 4; i++) begin
      prep_d.ch[i] = prep_chan(dec_i.ch[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

### hw/rtl/tfc_finish.sv
// ----------------------------------------------------------------------------
// tfc_finish
// third stage: half rounding, unorm shifts, packing into the output register
// ----------------------------------------------------------------------------
module tfc_finish
  import tfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  prep_t       prep_i,
  output logic        valid_o,
  output logic [63:0] raw_o,
  output logic        last_o
);

  logic        valid_q;
  logic [63:0] raw_d, raw_q;
  logic        last_q;

  // round n/65535 to half, nearest even (ties cannot occur)
  function automatic logic [15:0] to_half(input chp_t c);
    logic [10:0] hi;
    logic [16:0] s;
    logic [16:0] r;
    logic [11:0] q;
    logic [3:0]  e;
    hi = c.f_norm[15:5];
    s  = 17'(hi) + {1'b0, c.f_norm[4:0], 11'b0};
    if (s >= 17'(UNORM16_MAX)) begin
      q = 12'(hi) + 12'd1;
      r = s - 17'(UNORM16_MAX);
    end else begin
      q = 12'(hi);
      r = s;
    end
    if (r[16] || r[15]) q = q + 12'd1;
    e = c.f_exp - 4'd2;
    if (c.f_zero) return 16'd0;
    if (c.f_one)  return HALF_ONE;
    if (c.f_tiny) return {6'b0, c.u[1:0], 8'b0};
    return {2'b0, e, 10'b0} + {4'b0, q};
  endfunction

  function automatic logic [7:0] half_to_u8(input chp_t c);
    logic [18:0] v;
    v = c.h_p8 >> c.h_sh;
    if (c.h_sat)  return UNORM8_MAX;
    if (c.h_zero) return 8'd0;
    return v[7:0];
  endfunction

  function automatic logic [15:0] half_to_u16(input chp_t c);
    logic [26:0] v;
    v = c.h_p16 >> c.h_sh;
    if (c.h_sat)  return UNORM16_MAX;
    if (c.h_zero) return 16'd0;
    return v[15:0];
  endfunction

  always_comb begin
    logic [3:0][7:0]  b;
    logic [3:0][15:0] w;
    logic [7:0]       t;
    b     = '0;
    w     = '0;
    t     = '0;
    raw_d = '0;
    for (int i = 0; i < 4; i++) begin
      b[i] = prep_i.is_half ? half_to_u8(prep_i.ch[i]) : prep_i.ch[i].u8;
    end
    if (prep_i.swap_rb) begin
      t    = b[0];
      b[0] = b[2];
      b[2] = t;
    end
    case (prep_i.mode)
      MODE_PASS: raw_d = prep_i.raw;
      MODE_U8:   raw_d = {32'b0, b};
      MODE_U16: begin
        for (int i = 0; i < 4; i++) begin
          w[i] = prep_i.is_half ? half_to_u16(prep_i.ch[i]) : prep_i.ch[i].u;
        end
        raw_d = w;
      end
      MODE_HALF: begin
        for (int i = 0; i < 4; i++) begin
          w[i] = prep_i.is_half ? prep_i.ch[i].u : to_half(prep_i.ch[i]);
        end
        raw_d = w;
      end
      default:   raw_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q  <= raw_d;
      last_q <= prep_i.last;
    end
  end

  assign valid_o = valid_q;
  assign raw_o   = raw_q;
  assign last_o  = last_q;

endmodule

### hw/rtl/texel_format_converter.sv
// ----------------------------------------------------------------------------
// texel_format_converter
// Converts one texel word per clock, while the output accepts words, between
// RGBA8, BGRA8, RGBA16 unorm and RGBA16 half, and reads compressed HDR (an
// HDR target only passes its own format through, else gives zero). A word
// passes three register stages (decode, prepare, finish). Each stage
// holds its word when the stage after it is full and stalled, and empty
// stages fill while the output waits; in_ready_o follows out_ready_i through
// that stage chain within the same cycle. Formats are set through the write
// port and must change only while no word is in flight.
// ----------------------------------------------------------------------------
module texel_format_converter
  import tfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] raw_in_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] raw_out_o,
  output logic        last_out_o
);

  logic [2:0] src_fmt_q, dst_fmt_q;
  logic       s1_valid, s2_valid, s3_valid;
  logic       s1_en, s2_en, s3_en;
  dec_t       s1_dec;
  prep_t      s2_prep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= SOURCE_FORMAT_RESET;
      dst_fmt_q <= TARGET_FORMAT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_FORMAT: src_fmt_q <= cfg_data_i;
        CFG_TARGET_FORMAT: dst_fmt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its word moves on
  assign s3_en      = !s3_valid || out_ready_i;
  assign s2_en      = !s2_valid || s3_en;
  assign s1_en      = !s1_valid || s2_en;
  assign in_ready_o = s1_en;

  tfc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_en),
    .valid_i   (in_valid_i),
    .src_fmt_i (src_fmt_q),
    .dst_fmt_i (dst_fmt_q),
    .raw_i     (raw_in_i),
    .last_i    (last_in_i),
    .valid_o   (s1_valid),
    .dec_o     (s1_dec)
  );

  tfc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s2_en),
    .valid_i (s1_valid),
    .dec_i   (s1_dec),
    .valid_o (s2_valid),
    .prep_o  (s2_prep)
  );

  tfc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s3_en),
    .valid_i (s2_valid),
    .prep_i  (s2_prep),
    .valid_o (s3_valid),
    .raw_o   (raw_out_o),
    .last_o  (last_out_o)
  );

  assign out_valid_o = s3_valid;

endmodule

### hw/rtl/tfc_checker.sv
// ----------------------------------------------------------------------------
// tfc_checker
// port level checks of the texel format converter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] raw_out_o,
  input logic        last_out_o
);

  // stalled output word holds
  `TFC_ASSERT_IMPL(a_out_hold, out_valid_o && !out_ready_i,
                   ##1 (out_valid_o && $stable(raw_out_o) && $stable(last_out_o)),
                   "output word changed while stalled")

  // empty output means the pipeline takes a word
  `TFC_ASSERT_IMPL(a_ready_when_empty, !out_valid_o, in_ready_o,
                   "input not ready with empty output")

  // an accepted word reaches the output while the sink stays ready
  `TFC_ASSERT(a_latency,
              (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
              |=> out_valid_o,
              "accepted word did not reach the output in three cycles")

endmodule

bind texel_format_converter tfc_checker u_tfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .raw_out_o   (raw_out_o),
  .last_out_o  (last_out_o)
);

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the texel format converter. A short table of
// directed texels covers every format pair class, the extremes of the
// channels, the half specials and the unused format codes. A random phase
// then follows for every source and target pair. Each accepted word is
// predicted from the current format registers or from its table row, and
// checked in order against the output stream; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import tfc_pkg::*;

  localparam logic [2:0] FMT_RSVD6 = 3'd6;
  localparam logic [2:0] FMT_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int DIR_ROWS     = 26;

  typedef enum logic [1:0] {CH_U8, CH_U16, CH_HALF} chan_kind_e;

  typedef struct packed {
    chan_kind_e  kind;
    logic [15:0] v;
  } chan_t;

  typedef chan_t [3:0] texel_chans_t;

  typedef struct packed {
    logic [63:0] raw;
    logic        last;
  } texel_result_t;

  typedef struct packed {
    logic [2:0]  src;
    logic [2:0]  dst;
    logic [63:0] raw;
    logic        last;
    logic        has_want;
    logic [63:0] want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = CFG_SOURCE_FORMAT;
  logic [2:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [63:0] raw_in_i    = '0;
  logic        last_in_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] raw_out_o;
  logic        last_out_o;

  // fixed result of the word being offered, used by the directed table
  logic        word_has_want = 1'b0;
  logic [63:0] word_want     = '0;

  logic [2:0]    src_shadow = SOURCE_FORMAT_RESET;
  logic [2:0]    dst_shadow = TARGET_FORMAT_RESET;
  logic [2:0]    cur_src    = SOURCE_FORMAT_RESET;
  logic [2:0]    cur_dst    = TARGET_FORMAT_RESET;
  texel_result_t pending_texels [$];
  int            error_count = 0;
  int            cycle_count = 0;
  int            burst_left  = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FMT_RGBA8,     FMT_BGRA8,     64'hcafe_f00d_4433_2211, 1'b0, 1'b1, 64'h0000_0000_4411_2233},
    '{FMT_RGBA8,     FMT_RGBA8,     64'hdead_beef_8040_c0ff, 1'b1, 1'b1, 64'h0000_0000_8040_c0ff},
    '{FMT_RGBA8,     FMT_RGBA16,    64'h0000_0000_00ff_00ff, 1'b0, 1'b1, 64'h0000_ffff_0000_ffff},
    '{FMT_RGBA8,     FMT_RGBA16,    64'hffff_ffff_0000_0000, 1'b0, 1'b1, 64'h0000_0000_0000_0000},
    '{FMT_RGBA8,     FMT_HALF,      64'h0000_0000_ff00_00ff, 1'b0, 1'b1, 64'h3c00_0000_0000_3c00},
    '{FMT_RGBA8,     FMT_HALF,      64'h0000_0000_0180_7f02, 1'b0, 1'b0, 64'h0},
    '{FMT_BGRA8,     FMT_RGBA16,    64'h0000_0000_8040_2010, 1'b0, 1'b0, 64'h0},
    '{FMT_BGRA8,     FMT_HALF,      64'h0000_0000_7f80_01fe, 1'b1, 1'b0, 64'h0},
    '{FMT_RGBA16,    FMT_RGBA16,    64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 64'hffff_ffff_ffff_ffff},
    '{FMT_RGBA16,    FMT_RGBA8,     64'h8000_ffff_0101_0100, 1'b0, 1'b0, 64'h0},
    '{FMT_RGBA16,    FMT_HALF,      64'h0001_0002_7fff_8000, 1'b0, 1'b0, 64'h0},
    '{FMT_RGBA16,    FMT_HALF,      64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'h3c00_3c00_3c00_3c00},
    '{FMT_HALF,      FMT_RGBA8,     64'h8000_fc00_7c00_7e00, 1'b0, 1'b1, 64'h0000_0000_0000_ffff},
    '{FMT_HALF,      FMT_RGBA16,    64'h8000_fc00_7c00_7e00, 1'b0, 1'b1, 64'h0000_0000_ffff_ffff},
    '{FMT_HALF,      FMT_RGBA16,    64'h0400_0001_3bff_3c00, 1'b0, 1'b0, 64'h0},
    '{FMT_HALF,      FMT_BGRA8,     64'h3800_03ff_3555_0200, 1'b0, 1'b0, 64'h0},
    '{FMT_HALF,      FMT_HALF,      64'hffff_0000_7e00_8000, 1'b1, 1'b1, 64'hffff_0000_7e00_8000},
    '{FMT_RGBA8_HDR, FMT_RGBA16,    64'h1234_5678_ffff_ffff, 1'b0, 1'b1, 64'hffff_ffff_ffff_ffff},
    '{FMT_BGRA8_HDR, FMT_RGBA8,     64'h0000_0000_0110_0802, 1'b0, 1'b0, 64'h0},
    '{FMT_RGBA8_HDR, FMT_HALF,      64'h0000_0000_00ff_ffff, 1'b0, 1'b1, 64'h3c00_0000_0000_0000},
    '{FMT_RGBA8_HDR, FMT_RGBA8_HDR, 64'haaaa_5555_1234_abcd, 1'b0, 1'b1, 64'h0000_0000_1234_abcd},
    '{FMT_RGBA16,    FMT_BGRA8_HDR, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h0},
    '{FMT_RSVD7,     FMT_RGBA16,    64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, 64'h0},
    '{FMT_RSVD6,     FMT_HALF,      64'h1234_5678_9abc_def0, 1'b0, 1'b1, 64'h0},
    '{FMT_RGBA8,     FMT_RSVD6,     64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'h0},
    '{FMT_RSVD7,     FMT_RSVD7,     64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'h0}
  };

  texel_format_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_in_i    (raw_in_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .raw_out_o   (raw_out_o),
    .last_out_o  (last_out_o)
  );

  function automatic logic [15:0] half_to_unorm(logic [15:0] h, logic [15:0] k);
    logic [4:0]  ex;
    logic [10:0] m;
    logic [31:0] prod;
    int          sh;
    ex = h[14:10];
    if (ex == HALF_EXP_MAX) begin
      if (h[9:0] != 10'd0) return k;
      return h[15] ? 16'd0 : k;
    end
    if (h[15]) return 16'd0;
    if (ex >= HALF_EXP_BIAS) return k;
    if (ex == 5'd0) begin
      m  = {1'b0, h[9:0]};
      sh = 24;
    end else begin
      m  = {1'b1, h[9:0]};
      sh = 25 - int'(ex);
    end
    prod = 32'(m) * 32'(k);
    return 16'(prod >> sh);
  endfunction

  function automatic logic [31:0] div_round_even(logic [63:0] num, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = num / d;
    r = num % d;
    if ((2 * r > d) || ((2 * r == d) && q[0])) q = q + 1;
    return q[31:0];
  endfunction

  function automatic logic [15:0] ratio_to_half(logic [15:0] n, logic [15:0] d);
    int          t;
    logic [31:0] q;
    logic [31:0] bexp;
    if (n == 16'd0) return 16'd0;
    if (n >= d) return HALF_ONE;
    t = 1;
    while ((t < 20) && ((64'(n) << t) < 64'(d))) t++;
    if (t < 15) begin
      q    = div_round_even(64'(n) << (t + 10), 64'(d));
      bexp = 32'(15 - t);
      return 16'((bexp << 10) + q - 32'd1024);
    end
    return 16'(div_round_even(64'(n) << 24, 64'(d)));
  endfunction

  function automatic logic [15:0] chan_to_u8(chan_t c);
    case (c.kind)
      CH_U8:   return {8'h00, c.v[7:0]};
      CH_U16:  return c.v / 16'd257;
      default: return half_to_unorm(c.v, {8'h00, UNORM8_MAX});
    endcase
  endfunction

  function automatic logic [15:0] chan_to_u16(chan_t c);
    case (c.kind)
      CH_U8:   return 16'(c.v[7:0]) * 16'd257;
      CH_U16:  return c.v;
      default: return half_to_unorm(c.v, UNORM16_MAX);
    endcase
  endfunction

  function automatic logic [15:0] chan_to_half(chan_t c);
    case (c.kind)
      CH_U8:   return ratio_to_half({8'h00, c.v[7:0]}, {8'h00, UNORM8_MAX});
      CH_U16:  return ratio_to_half(c.v, UNORM16_MAX);
      default: return c.v;
    endcase
  endfunction

  function automatic texel_chans_t decode_texel(logic [2:0] fmt, logic [63:0] raw);
    texel_chans_t ch;
    logic [19:0]  p;
    logic [7:0]   a;
    for (int i = 0; i < 4; i++) begin
      ch[i].kind = CH_U16;
      ch[i].v    = 16'd0;
    end
    case (fmt)
      FMT_RGBA8, FMT_BGRA8: begin
        for (int i = 0; i < 4; i++) begin
          ch[i].kind = CH_U8;
          ch[i].v    = {8'h00, raw[8*i +: 8]};
        end
        if (fmt == FMT_BGRA8) begin
          ch[0].v = {8'h00, raw[23:16]};
          ch[2].v = {8'h00, raw[7:0]};
        end
      end
      FMT_RGBA8_HDR, FMT_BGRA8_HDR: begin
        a = raw[31:24];
        for (int i = 0; i < 3; i++) begin
          p       = 20'(raw[(2-i)*8 +: 8]) * 20'(a) * 20'd16;
          ch[i].v = (p > 20'h0ffff) ? UNORM16_MAX : p[15:0];
        end
        ch[3].v = UNORM16_MAX;
      end
      FMT_RGBA16, FMT_HALF: begin
        for (int i = 0; i < 4; i++) begin
          ch[i].kind = (fmt == FMT_HALF) ? CH_HALF : CH_U16;
          ch[i].v    = raw[16*i +: 16];
        end
      end
      default: ;
    endcase
    return ch;
  endfunction

  function automatic logic [63:0] encode_texel(logic [2:0] fmt, texel_chans_t ch);
    logic [63:0]      r;
    logic [3:0][7:0]  b;
    logic [7:0]       t;
    r = '0;
    case (fmt)
      FMT_RGBA8, FMT_BGRA8: begin
        for (int i = 0; i < 4; i++) b[i] = 8'(chan_to_u8(ch[i]));
        if (fmt == FMT_BGRA8) begin
          t    = b[0];
          b[0] = b[2];
          b[2] = t;
        end
        r = {32'h0, b};
      end
      FMT_RGBA16: for (int i = 0; i < 4; i++) r[16*i +: 16] = chan_to_u16(ch[i]);
      FMT_HALF:   for (int i = 0; i < 4; i++) r[16*i +: 16] = chan_to_half(ch[i]);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] convert_texel(logic [2:0] src, logic [2:0] dst,
                                                logic [63:0] raw);
    if (dst > FMT_HALF) return '0;
    if (src == dst) return (dst >= FMT_RGBA16) ? raw : {32'h0, raw[31:0]};
    if ((dst == FMT_RGBA8_HDR) || (dst == FMT_BGRA8_HDR)) return '0;
    return encode_texel(dst, decode_texel(src, raw));
  endfunction

  function automatic logic [7:0] rand_u8();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return UNORM8_MAX;
      2:       return 8'($urandom_range(1, 15));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_u16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return UNORM16_MAX;
      2:       return 16'($urandom_range(1, 300));
      3:       return 16'($urandom_range(16'hff00, 16'hfffe));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7c00;
      3:       return 16'hfc00;
      4:       return {1'($urandom), HALF_EXP_MAX, 10'($urandom_range(1, 1023))};
      5:       return HALF_ONE;
      6:       return {6'b0, 10'($urandom)};
      7, 8:    return {1'b0, 5'($urandom_range(1, 14)), 10'($urandom)};
      9:       return {1'b0, 5'($urandom_range(15, 30)), 10'($urandom)};
      10:      return {1'b1, 15'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_texel(logic [2:0] fmt);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return r;
    for (int i = 0; i < 4; i++) begin
      case (fmt)
        FMT_RGBA8, FMT_BGRA8, FMT_RGBA8_HDR, FMT_BGRA8_HDR: r[8*i +: 8] = rand_u8();
        FMT_RGBA16: r[16*i +: 16] = rand_u16();
        FMT_HALF:   r[16*i +: 16] = rand_half();
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_texel(input logic [63:0] raw, input logic last,
                            input logic has_want, input logic [63:0] want);
    int gap;
    in_valid_i    <= 1'b1;
    raw_in_i      <= raw;
    last_in_i     <= last;
    word_has_want <= has_want;
    word_want     <= want;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_texels.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_formats(input logic [2:0] src, input logic [2:0] dst);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SOURCE_FORMAT;
    cfg_data_i <= src;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TARGET_FORMAT;
    cfg_data_i <= dst;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_src = src;
    cur_dst = dst;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in segments of random mode and length
  initial begin
    int seg;
    int mode;
    forever begin
      seg  = $urandom_range(5, 40);
      mode = $urandom_range(0, 4);
      repeat (seg) begin
        @(posedge clk_i);
        case (mode)
          0, 1:    out_ready_i <= 1'b1;
          2:       out_ready_i <= 1'($urandom_range(0, 1));
          3:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    texel_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SOURCE_FORMAT) src_shadow = cfg_data_i;
        else dst_shadow = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        want.raw  = word_has_want ? word_want : convert_texel(src_shadow, dst_shadow, raw_in_i);
        want.last = last_in_i;
        pending_texels.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_texels.size() == 0) begin
          $display("%0t: unexpected word raw_out %h last_out %b", $time, raw_out_o,
                   last_out_o);
          error_count++;
        end else begin
          want = pending_texels.pop_front();
          if (raw_out_o !== want.raw) begin
            $display("%0t: raw_out expected %h actual %h", $time, want.raw, raw_out_o);
            error_count++;
          end
          if (last_out_o !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, last_out_o);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [2:0] src_fmt;
    logic [2:0] dst_fmt;
    int         n;
    @(posedge rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < DIR_ROWS; i++) begin
      if ((dir_rows[i].src != cur_src) || (dir_rows[i].dst != cur_dst)) begin
        settle();
        program_formats(dir_rows[i].src, dir_rows[i].dst);
      end
      send_texel(dir_rows[i].raw, dir_rows[i].last, dir_rows[i].has_want, dir_rows[i].want);
    end
    for (int p = 0; p < 64; p++) begin
      src_fmt = 3'(p >> 3);
      dst_fmt = 3'(p);
      settle();
      program_formats(src_fmt, dst_fmt);
      n = $urandom_range(14, 26);
      repeat (n) send_texel(rand_texel(src_fmt), ($urandom_range(0, 15) == 0), 1'b0, '0);
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((error_count == 0) && (pending_texels.size() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tfc_pkg.sv
hw/rtl/tfc_decode.sv
hw/rtl/tfc_prep.sv
hw/rtl/tfc_finish.sv
hw/rtl/texel_format_converter.sv
hw/rtl/tfc_checker.sv
test/tb_top.sv
